// ----- sv/pst_pkg.sv -----
// pst_pkg: shared constants and types for the prime sieve table core
// no dependencies; used by pst_sieve_engine, pst_prime_table and prime_sieve_table_core
`timescale 1ns / 1ps
package pst_pkg;

  localparam int MAX_LIMIT   = 65536;
  localparam int ADDR_W      = $clog2(MAX_LIMIT);
  localparam int LIM_W       = ADDR_W + 1;
  localparam int ROOT_W      = ADDR_W / 2 + 1;
  localparam int PRIME_DEPTH = 6542;
  localparam int PADDR_W     = $clog2(PRIME_DEPTH);

  localparam int LIMIT_W = 17;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 13;
  localparam int VALUE_W = 16;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 32;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               start;
    logic [LIM_W-1:0]   lim;
  } pst_ctl_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } pst_sts_t;

  typedef struct packed {
    logic               en;
    logic [PADDR_W-1:0] addr;
    logic [VALUE_W-1:0] data;
  } pst_wr_t;

endpackage

// ----- sv/pst_prime_table.sv -----
// pst_prime_table: prime list store, one write port from the sieve engine
// and one registered read port for queries; depends on pst_pkg
`timescale 1ns / 1ps
module pst_prime_table (
  input  logic                           clk,
  input  pst_pkg::pst_wr_t               wr,
  input  logic [pst_pkg::PADDR_W-1:0]    rd_addr,
  output logic [pst_pkg::VALUE_W-1:0]    rd_data
);
  import pst_pkg::*;

  logic [VALUE_W-1:0] mem [PRIME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/pst_sieve_engine.sv -----
// pst_sieve_engine: flag store plus sequencer that clears, strikes multiples
// and packs primes into the prime table; depends on pst_pkg
`timescale 1ns / 1ps
module pst_sieve_engine (
  input  logic              clk,
  input  logic              rst,
  input  pst_pkg::pst_ctl_t ctl,
  output pst_pkg::pst_sts_t sts,
  output pst_pkg::pst_wr_t  pwr
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    IDLE, CLEAR, CHECK, TEST, STRIKE, PACK, DRAIN, DONE
  } state_t;

  state_t              state;
  logic [LIM_W-1:0]    lim;
  logic [ADDR_W-1:0]   a;
  logic [ROOT_W-1:0]   j;
  logic [LIM_W-1:0]    sq;
  logic [LIM_W-1:0]    k;
  logic [COUNT_W-1:0]  cnt;
  logic                p_v;
  logic [ADDR_W-1:0]   p_a;
  logic                done;

  logic                flags [MAX_LIMIT];
  logic                rd_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic                fwr_en;
  logic [ADDR_W-1:0]   fwr_addr;
  logic                fwr_bit;

  logic [LIM_W-1:0]    a_inc;
  logic [LIM_W-1:0]    k_next;
  logic [LIM_W-1:0]    sq_next;
  logic [ROOT_W-1:0]   j_next;
  logic                take;

  assign a_inc   = LIM_W'(a) + LIM_W'(1);
  assign k_next  = k + LIM_W'(j);
  assign sq_next = sq + LIM_W'({j, 1'b0}) + LIM_W'(1);
  assign j_next  = j + ROOT_W'(1);
  assign take    = p_v && !rd_data && (32'(cnt) < 32'(PRIME_DEPTH));

  always_comb begin
    rd_addr  = (state == CHECK) ? ADDR_W'(j) : a;
    fwr_en   = 1'b0;
    fwr_addr = a;
    fwr_bit  = 1'b0;
    if (state == CLEAR) begin
      fwr_en  = 1'b1;
      fwr_bit = (a_inc <= LIM_W'(2));
    end else if (state == STRIKE) begin
      fwr_en   = 1'b1;
      fwr_addr = k[ADDR_W-1:0];
      fwr_bit  = 1'b1;
    end
  end

  // flag store
  always_ff @(posedge clk) begin
    if (fwr_en) begin
      flags[fwr_addr] <= fwr_bit;
    end
    rd_data <= flags[rd_addr];
  end

  assign pwr.en   = take;
  assign pwr.addr = cnt[PADDR_W-1:0];
  assign pwr.data = p_a[VALUE_W-1:0];

  assign sts.done  = done;
  assign sts.count = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      p_v   <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      p_v  <= (state == PACK);
      p_a  <= a;
      if (take) begin
        cnt <= cnt + COUNT_W'(1);
      end
      unique case (state)
        IDLE: begin
          if (ctl.start) begin
            lim <= ctl.lim;
            a   <= '0;
            cnt <= '0;
            if (ctl.lim < LIM_W'(2)) begin
              state <= DONE;
            end else begin
              state <= CLEAR;
            end
          end
        end
        CLEAR: begin
          a <= a_inc[ADDR_W-1:0];
          if (a_inc == lim) begin
            j     <= ROOT_W'(2);
            sq    <= LIM_W'(4);
            state <= CHECK;
          end
        end
        CHECK: begin
          if (sq < lim) begin
            state <= TEST;
          end else begin
            a     <= '0;
            state <= PACK;
          end
        end
        TEST: begin
          if (!rd_data) begin
            k     <= sq;
            state <= STRIKE;
          end else begin
            j     <= j_next;
            sq    <= sq_next;
            state <= CHECK;
          end
        end
        STRIKE: begin
          k <= k_next;
          if (k_next >= lim) begin
            j     <= j_next;
            sq    <= sq_next;
            state <= CHECK;
          end
        end
        PACK: begin
          a <= a_inc[ADDR_W-1:0];
          if (a_inc == lim) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= DONE;
        end
        DONE: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sv/prime_sieve_table_core.sv -----
// prime_sieve_table_core: sieve of eratosthenes with prime lookup, top level
// query: the prime table read is registered at accept, then the result word is registered from it in the QUERY state
// build: the sieve engine clears the flag store, strikes multiples and packs the primes, then
// the result word is registered; a limit below 2 skips the flag store walk
// one word in flight at a time; next word accepted at the edge the result is taken
// reset clears control state and the prime count; stores are not swept
`timescale 1ns / 1ps
module prime_sieve_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pst_pkg::S_DATA_W-1:0]    s_tdata,   // limit, index, zero pad
  input  logic                            s_tuser,   // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pst_pkg::M_DATA_W-1:0]    m_tdata,   // prime_count, prime_value, zero pad
  output logic                            m_tuser    // bad_index
);
  import pst_pkg::*;

  typedef enum logic [1:0] {IDLE, BUILD, QUERY} state_t;

  state_t              state;
  logic [COUNT_W-1:0]  count;
  logic                bad;

  logic [LIMIT_W-1:0]  limit;
  logic [INDEX_W-1:0]  index;
  logic                accept;
  logic [LIM_W-1:0]    lim_sat;
  logic [VALUE_W-1:0]  prime_rd;

  pst_ctl_t ctl;
  pst_sts_t sts;
  pst_wr_t  pwr;

  assign limit    = s_tdata[LIMIT_W-1:0];
  assign index    = s_tdata[LIMIT_W+INDEX_W-1:LIMIT_W];
  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign lim_sat  = (32'(limit) > 32'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT) : LIM_W'(limit);

  assign ctl.start = accept && (s_tuser == KIND_BUILD);
  assign ctl.lim   = lim_sat;

  pst_sieve_engine u_engine (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .pwr (pwr)
  );

  pst_prime_table u_table (
    .clk     (clk),
    .wr      (pwr),
    .rd_addr (index[PADDR_W-1:0]),
    .rd_data (prime_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_BUILD) begin
              state <= BUILD;
            end else begin
              bad   <= !(32'(index) < 32'(count));
              state <= QUERY;
            end
          end
        end
        BUILD: begin
          if (sts.done) begin
            count    <= sts.count;
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'({VALUE_W'(0), sts.count});
            m_tuser  <= 1'b0;
            state    <= IDLE;
          end
        end
        QUERY: begin
          m_tvalid <= 1'b1;
          m_tdata  <= M_DATA_W'({(bad ? VALUE_W'(0) : prime_rd), count});
          m_tuser  <= bad;
          state    <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- tb/prime_sieve_checker.sv -----
// prime_sieve_checker: watches both stream channels of prime_sieve_table_core, predicts
// each answer word from its own sieve and compares field by field; depends on pst_pkg
`timescale 1ns / 1ps
module prime_sieve_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [pst_pkg::S_DATA_W-1:0] s_tdata,   // limit, index, zero pad
  input  logic                         s_tuser,   // kind
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [pst_pkg::M_DATA_W-1:0] m_tdata,   // prime_count, prime_value, zero pad
  input  logic                         m_tuser,   // bad_index
  output int                           mismatch_total,
  output int                           answers_due
);
  import pst_pkg::*;

  localparam int ANSWER_DEPTH = 16;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
    logic               bad;
  } sieve_answer_t;

  bit                 struck [0:MAX_LIMIT-1];
  logic [VALUE_W-1:0] prime_list [0:PRIME_DEPTH-1];
  int                 prime_total = 0;
  sieve_answer_t      answer_buf [0:ANSWER_DEPTH-1];
  int                 wr_slot = 0;
  int                 rd_slot = 0;
  int                 held = 0;
  int                 errors = 0;
  int                 due = 0;

  assign mismatch_total = errors;
  assign answers_due    = due;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (errors < 40)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
    errors++;
  endtask

  function automatic void run_sieve(input logic [LIMIT_W-1:0] lim_in);
    int lim, j, k;
    lim = (lim_in > MAX_LIMIT) ? MAX_LIMIT : int'(lim_in);
    prime_total = 0;
    if (lim < 2)
      return;
    for (k = 0; k < lim; k++)
      struck[k] = 1'b0;
    struck[0] = 1'b1;
    struck[1] = 1'b1;
    for (j = 2; j * j < lim; j++)
      if (!struck[j])
        for (k = j * j; k < lim; k += j)
          struck[k] = 1'b1;
    for (k = 0; k < lim; k++)
      if (!struck[k] && prime_total < PRIME_DEPTH) begin
        prime_list[prime_total] = k[VALUE_W-1:0];
        prime_total++;
      end
  endfunction

  function automatic sieve_answer_t answer_for(input logic kind, input logic [LIMIT_W-1:0] lim,
                                               input logic [INDEX_W-1:0] idx);
    sieve_answer_t a;
    a = '0;
    if (kind == KIND_BUILD) begin
      run_sieve(lim);
    end else if (int'(idx) < prime_total) begin
      a.value = prime_list[idx];
    end else begin
      a.bad = 1'b1;
    end
    a.count = prime_total[COUNT_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    sieve_answer_t got, want;
    if (rst) begin
      prime_total = 0;
      wr_slot = 0;
      rd_slot = 0;
      held = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (held == ANSWER_DEPTH) begin
          report_mismatch("words in flight", held + 1, ANSWER_DEPTH);
        end else begin
          answer_buf[wr_slot] = answer_for(s_tuser, s_tdata[LIMIT_W-1:0],
                                           s_tdata[LIMIT_W+INDEX_W-1:LIMIT_W]);
          wr_slot = (wr_slot + 1) % ANSWER_DEPTH;
          held++;
        end
      end
      if (m_tvalid && m_tready) begin
        got.count = m_tdata[COUNT_W-1:0];
        got.value = m_tdata[COUNT_W+VALUE_W-1:COUNT_W];
        got.bad   = m_tuser;
        if (held == 0) begin
          report_mismatch("unexpected result word, prime_count", int'(got.count), -1);
        end else begin
          want = answer_buf[rd_slot];
          rd_slot = (rd_slot + 1) % ANSWER_DEPTH;
          held--;
          if (got.count !== want.count)
            report_mismatch("prime_count", int'(got.count), int'(want.count));
          if (got.value !== want.value)
            report_mismatch("prime_value", int'(got.value), int'(want.value));
          if (got.bad !== want.bad)
            report_mismatch("bad_index", int'(got.bad), int'(want.bad));
        end
      end
    end
    due <= held;
  end

endmodule

// ----- tb/prime_sieve_table_core_tb.sv -----
// prime_sieve_table_core_tb: drives builds and prime lookups into prime_sieve_table_core
// under several flow-control phases; depends on pst_pkg and prime_sieve_checker
`timescale 1ns / 1ps
module prime_sieve_table_core_tb;
  import pst_pkg::*;

  localparam int PHASE_WORDS = 360;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // limit, index, zero pad
  logic                s_tuser = 1'b0; // kind
  logic                m_tvalid;
  logic                m_tready = 1'b1;
  logic [M_DATA_W-1:0] m_tdata;        // prime_count, prime_value, zero pad
  logic                m_tuser;        // bad_index

  int                 mismatch_total;
  int                 answers_due;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 builds_sent = 0;
  int                 queries_sent = 0;
  logic [LIMIT_W-1:0] last_lim = '0;

  prime_sieve_table_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  prime_sieve_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatch_total(mismatch_total), .answers_due(answers_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b1;
    else
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_word(input logic kind, input logic [LIMIT_W-1:0] lim,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_DATA_W-LIMIT_W-INDEX_W){1'b0}}, idx, lim};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    if (kind == KIND_BUILD) begin
      builds_sent++;
      last_lim = lim;
    end else begin
      queries_sent++;
    end
  endtask

  task automatic build(input logic [LIMIT_W-1:0] lim);
    send_word(KIND_BUILD, lim, INDEX_W'($urandom));
  endtask

  task automatic query(input logic [INDEX_W-1:0] idx);
    send_word(KIND_QUERY, LIMIT_W'($urandom), idx);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0)
      @(posedge clk);
  endtask

  task automatic random_word();
    int pick;
    int top_idx;
    pick = $urandom_range(0, 99);
    if (pick < 2)
      build(LIMIT_W'($urandom_range(0, 3)));
    else if (pick < 4)
      build(LIMIT_W'($urandom_range(201, 3000)));
    else if (pick < 25)
      build(LIMIT_W'($urandom_range(4, 200)));
    else if (pick < 85) begin
      top_idx = (last_lim > MAX_LIMIT) ? MAX_LIMIT / 3 + 2 : int'(last_lim) / 3 + 2;
      query(INDEX_W'($urandom_range(0, top_idx)));
    end else
      query(INDEX_W'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lookups before any build, then tiny limits
    query(0);
    query(16'hFFFF);
    build(0);
    build(1);
    query(0);
    build(2);
    build(3);
    query(0);
    query(1);
    // saturated limit, whole list
    build(17'h1FFFF);
    query(0);
    query(INDEX_W'(PRIME_DEPTH - 1));
    query(INDEX_W'(PRIME_DEPTH));
    query(16'hAAAA);
    query(16'h5555);
    query(16'hFFFF);
    // rebuild shrinks the list; square edges
    build(4);
    query(1);
    query(2);
    build(5);
    build(26);
    query(8);
    build(49);
    build(50);
    query(14);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          wait_drained();
          idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      repeat (PHASE_WORDS) random_word();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d sieve builds (saturating limit included) and %0d prime lookups",
             builds_sent, queries_sent);
    $display("across free-running, sender-idle, receiver-stall and mixed phases");
    if (mismatch_total == 0 && answers_due == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- prime_sieve_table_core.f -----
sv/pst_pkg.sv
sv/pst_prime_table.sv
sv/pst_sieve_engine.sv
sv/prime_sieve_table_core.sv
tb/prime_sieve_checker.sv
tb/prime_sieve_table_core_tb.sv
